/* rtl/tbo_pkg.sv */
// shared constants for the triangle / box overlap pipeline
// no dependencies
package tbo_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned HALF_W = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SPLIT_W = 32;

  localparam logic [HALF_W-1:0] HALF_RESET = 31'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 2'd2;

endpackage

/* rtl/triangle_box_overlap_test_core.sv */
// triangle versus axis-aligned box overlap test, separating-axis method
// depends on tbo_pkg
//
// usage
//   pulse start_i with a box center and three triangle vertices (signed
//   fixed point, COORD_WIDTH bits, 16 fraction bits for Q16.16); busy_o is
//   always low, so a new test can be started in every cycle
//   done_o strobes for one cycle with overlaps_o when the test leaves the
//   last pipeline stage; results come out in start order
//   throughput is one test per cycle, set by the eight-stage pipeline
//   (vertex offsets, edges, edge products, axis values, axis compares and
//   plane partial products, plane product merge, plane sums, final test)
//   the receiver cannot stall, so nothing ever backs up
//   half extents are written over the cfg channel (index 0..2 = x, y, z,
//   bits above 30 dropped, other indexes ignored); cfg_ready_o is always
//   high and writes belong between tests
//   reset clears the valid bits of every stage and loads the half extents
//   with 0.5 (32768); in-flight tests are dropped
module triangle_box_overlap_test_core #(
  parameter int unsigned COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [COORD_WIDTH-1:0]       center_x_i,
  input  logic signed [COORD_WIDTH-1:0]       center_y_i,
  input  logic signed [COORD_WIDTH-1:0]       center_z_i,
  input  logic signed [COORD_WIDTH-1:0]       a_x_i,
  input  logic signed [COORD_WIDTH-1:0]       a_y_i,
  input  logic signed [COORD_WIDTH-1:0]       a_z_i,
  input  logic signed [COORD_WIDTH-1:0]       b_x_i,
  input  logic signed [COORD_WIDTH-1:0]       b_y_i,
  input  logic signed [COORD_WIDTH-1:0]       b_z_i,
  input  logic signed [COORD_WIDTH-1:0]       c_x_i,
  input  logic signed [COORD_WIDTH-1:0]       c_y_i,
  input  logic signed [COORD_WIDTH-1:0]       c_z_i,
  output logic                                done_o,
  output logic                                overlaps_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tbo_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbo_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned HW  = tbo_pkg::HALF_W;
  localparam int unsigned LW  = tbo_pkg::SPLIT_W;
  localparam int unsigned VW  = W + 1;            // vertex offset
  localparam int unsigned EW  = W + 2;            // edge
  localparam int unsigned PW  = VW + EW;          // vertex times edge
  localparam int unsigned AW  = PW + 1;           // projection on an axis
  localparam int unsigned RPW = HW + EW;          // half extent times |edge|
  localparam int unsigned RW  = RPW + 1;          // projected radius
  localparam int unsigned CW  = ((AW > RW) ? AW : RW) + 2;
  localparam int unsigned FW  = ((VW > HW) ? VW : HW) + 2;
  localparam int unsigned NW  = 2 * EW + 1;       // normal component
  localparam int unsigned NHI = NW - LW;          // upper slice of normal
  localparam int unsigned NVLW = LW + 1 + VW;
  localparam int unsigned NVHW = NHI + VW;
  localparam int unsigned NVW = NW + VW;
  localparam int unsigned NHLW = LW + HW;
  localparam int unsigned NHHW = NHI + HW;
  localparam int unsigned NHW = NW + HW;
  localparam int unsigned DW  = NVW + 2;
  localparam int unsigned MW  = NHW + 2;
  localparam int unsigned SW  = ((DW > MW) ? DW : MW) + 2;

  // config registers
  logic [HW-1:0] h_q [3];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= tbo_pkg::HALF_RESET;
      h_q[1] <= tbo_pkg::HALF_RESET;
      h_q[2] <= tbo_pkg::HALF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tbo_pkg::CFG_HALF_X: h_q[0] <= cfg_data_i[HW-1:0];
        tbo_pkg::CFG_HALF_Y: h_q[1] <= cfg_data_i[HW-1:0];
        tbo_pkg::CFG_HALF_Z: h_q[2] <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with each stage
  logic [8:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:1], start_i && !busy_o};
    end
  end

  assign done_o = vld_q[8];

  // input gathering
  logic signed [W-1:0] in_c [3];
  logic signed [W-1:0] in_v [3][3];

  assign in_c[0] = center_x_i;
  assign in_c[1] = center_y_i;
  assign in_c[2] = center_z_i;
  assign in_v[0][0] = a_x_i;
  assign in_v[0][1] = a_y_i;
  assign in_v[0][2] = a_z_i;
  assign in_v[1][0] = b_x_i;
  assign in_v[1][1] = b_y_i;
  assign in_v[1][2] = b_z_i;
  assign in_v[2][0] = c_x_i;
  assign in_v[2][1] = c_y_i;
  assign in_v[2][2] = c_z_i;

  // stage registers
  logic signed [VW-1:0] v1_q [3][3];
  logic signed [VW-1:0] v2_q [3][3];
  logic signed [EW-1:0] e2_q [3][3];
  logic [EW-1:0]        eabs2_q [3][3];
  logic [2:0]           face2_q;
  logic signed [PW-1:0] pa3_q [9][3];
  logic signed [PW-1:0] pb3_q [9][3];
  logic [RPW-1:0]       ra3_q [9];
  logic [RPW-1:0]       rb3_q [9];
  logic signed [2*EW-1:0] nx1_3_q [3];
  logic signed [2*EW-1:0] nx2_3_q [3];
  logic signed [VW-1:0] v0_3_q [3];
  logic [2:0]           face3_q;
  logic signed [AW-1:0] p4_q [9][3];
  logic [RW-1:0]        rad4_q [9];
  logic signed [NW-1:0] n4_q [3];
  logic [NW-1:0]        nabs4_q [3];
  logic signed [VW-1:0] v0_4_q [3];
  logic [2:0]           face4_q;
  logic                 sep5_q;
  logic signed [NVLW-1:0] nvl5_q [3];
  logic signed [NVHW-1:0] nvh5_q [3];
  logic [NHLW-1:0]      nhl5_q [3];
  logic [NHHW-1:0]      nhh5_q [3];
  logic                 sep6_q;
  logic signed [NVW-1:0] nv6_q [3];
  logic [NHW-1:0]       nh6_q [3];
  logic                 sep7_q;
  logic signed [DW-1:0] d7_q;
  logic [MW-1:0]        m7_q;
  logic                 ovl8_q;

  logic [8:0] axis_sep_d;
  logic       sep5_d;
  logic signed [DW-1:0] d7_d;
  logic [MW-1:0]        m7_d;
  logic signed [SW-1:0] near_d, far_d;
  logic                 ovl8_d;

  genvar gi, gk, ge;

  generate
    for (gi = 0; gi < 3; gi++) begin : g_vert
      localparam int unsigned NI = (gi + 1) % 3;
      for (gk = 0; gk < 3; gk++) begin : g_comp
        logic signed [VW-1:0] v1_d;
        logic signed [EW-1:0] e2_d;
        assign v1_d = VW'(in_v[gi][gk]) - VW'(in_c[gk]);
        assign e2_d = EW'(v1_q[NI][gk]) - EW'(v1_q[gi][gk]);
        always_ff @(posedge clk_i) begin
          v1_q[gi][gk]    <= v1_d;
          v2_q[gi][gk]    <= v1_q[gi][gk];
          e2_q[gi][gk]    <= e2_d;
          eabs2_q[gi][gk] <= e2_d[EW-1] ? EW'(-e2_d) : EW'(e2_d);
        end
      end
    end

    // box face axes: all three vertices beyond the same face
    for (gk = 0; gk < 3; gk++) begin : g_face
      logic signed [FW-1:0] hp, hn, x0, x1, x2;
      assign hp = FW'({1'b0, h_q[gk]});
      assign hn = -hp;
      assign x0 = FW'(v1_q[0][gk]);
      assign x1 = FW'(v1_q[1][gk]);
      assign x2 = FW'(v1_q[2][gk]);
      always_ff @(posedge clk_i) begin
        face2_q[gk] <= (x0 > hp && x1 > hp && x2 > hp) ||
                       (x0 < hn && x1 < hn && x2 < hn);
        v0_3_q[gk]  <= v2_q[0][gk];
        v0_4_q[gk]  <= v0_3_q[gk];
      end
    end

    // edge cross axis: products, sums, compares
    for (ge = 0; ge < 3; ge++) begin : g_edge
      for (gk = 0; gk < 3; gk++) begin : g_axis
        localparam int unsigned AX = ge * 3 + gk;
        localparam int unsigned IA = (gk + 1) % 3;
        localparam int unsigned IB = (gk + 2) % 3;
        logic signed [CW-1:0] rp, rn;
        logic [2:0] above, below;
        always_ff @(posedge clk_i) begin
          ra3_q[AX]  <= RPW'(h_q[IA]) * RPW'(eabs2_q[ge][IB]);
          rb3_q[AX]  <= RPW'(h_q[IB]) * RPW'(eabs2_q[ge][IA]);
          rad4_q[AX] <= RW'(ra3_q[AX]) + RW'(rb3_q[AX]);
        end
        assign rp = CW'({1'b0, rad4_q[AX]});
        assign rn = -rp;
        for (gi = 0; gi < 3; gi++) begin : g_pt
          logic signed [PW-1:0] pa_d, pb_d;
          logic signed [CW-1:0] pe;
          assign pa_d = v2_q[gi][IB] * e2_q[ge][IA];
          assign pb_d = v2_q[gi][IA] * e2_q[ge][IB];
          always_ff @(posedge clk_i) begin
            pa3_q[AX][gi] <= pa_d;
            pb3_q[AX][gi] <= pb_d;
            p4_q[AX][gi]  <= AW'(pa3_q[AX][gi]) - AW'(pb3_q[AX][gi]);
          end
          assign pe = CW'(p4_q[AX][gi]);
          assign above[gi] = pe > rp;
          assign below[gi] = pe < rn;
        end
        assign axis_sep_d[AX] = (&above) || (&below);
      end
    end

    // triangle normal and plane partial products
    for (gk = 0; gk < 3; gk++) begin : g_norm
      localparam int unsigned IA = (gk + 1) % 3;
      localparam int unsigned IB = (gk + 2) % 3;
      logic signed [2*EW-1:0] nx1_d, nx2_d;
      logic signed [NW-1:0]   n4_d;
      logic [LW-1:0]          n_lo, na_lo;
      logic signed [NHI-1:0]  n_hi;
      logic [NHI-1:0]         na_hi;
      assign nx1_d = e2_q[0][IA] * e2_q[1][IB];
      assign nx2_d = e2_q[0][IB] * e2_q[1][IA];
      assign n4_d  = NW'(nx1_3_q[gk]) - NW'(nx2_3_q[gk]);
      assign n_lo  = n4_q[gk][LW-1:0];
      assign n_hi  = n4_q[gk][NW-1:LW];
      assign na_lo = nabs4_q[gk][LW-1:0];
      assign na_hi = nabs4_q[gk][NW-1:LW];
      always_ff @(posedge clk_i) begin
        nx1_3_q[gk] <= nx1_d;
        nx2_3_q[gk] <= nx2_d;
        n4_q[gk]    <= n4_d;
        nabs4_q[gk] <= n4_d[NW-1] ? NW'(-n4_d) : NW'(n4_d);
        nvl5_q[gk]  <= NVLW'($signed({1'b0, n_lo})) * NVLW'(v0_4_q[gk]);
        nvh5_q[gk]  <= NVHW'(n_hi) * NVHW'(v0_4_q[gk]);
        nhl5_q[gk]  <= NHLW'(na_lo) * NHLW'(h_q[gk]);
        nhh5_q[gk]  <= NHHW'(na_hi) * NHHW'(h_q[gk]);
        nv6_q[gk]   <= (NVW'(nvh5_q[gk]) <<< LW) + NVW'(nvl5_q[gk]);
        nh6_q[gk]   <= (NHW'(nhh5_q[gk]) << LW) + NHW'(nhl5_q[gk]);
      end
    end
  endgenerate

  assign sep5_d = (|axis_sep_d) || (|face4_q);

  // plane offset and radius of the box along the normal
  assign d7_d = -(DW'(nv6_q[0]) + DW'(nv6_q[1]) + DW'(nv6_q[2]));
  assign m7_d = MW'(nh6_q[0]) + MW'(nh6_q[1]) + MW'(nh6_q[2]);

  // nearest corner on or below the plane, farthest on or above it
  assign near_d = SW'(d7_q) - SW'({1'b0, m7_q});
  assign far_d  = SW'(d7_q) + SW'({1'b0, m7_q});
  assign ovl8_d = !sep7_q && (near_d <= 0) && (far_d >= 0);

  always_ff @(posedge clk_i) begin
    face3_q <= face2_q;
    face4_q <= face3_q;
    sep5_q  <= sep5_d;
    sep6_q  <= sep5_q;
    sep7_q  <= sep6_q;
    d7_q    <= d7_d;
    m7_q    <= m7_d;
    ovl8_q  <= ovl8_d;
  end

  assign overlaps_o = ovl8_q;

endmodule
